FILE: hdl/assert_macros.svh
// Assertion macros shared by the debounce RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, disabled while the asynchronous reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also runs during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/bidh_pkg.sv
// Package for the binary input debounce with hold-on delay.
// Holds register indexes, value codes and reset values; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bidh_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned VALUE_W = 16;
	localparam int unsigned MS_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_BOUNCE_MS = 3'd0;
	localparam cfg_idx_t REG_HOLD_MS = 3'd1;
	localparam cfg_idx_t REG_INVERT_LEVEL = 3'd2;
	localparam cfg_idx_t REG_ON_VALUE = 3'd3;
	localparam cfg_idx_t REG_OFF_VALUE = 3'd4;

	localparam logic signed [VALUE_W-1:0] NO_VALUE = -16'sd1;
	localparam logic signed [VALUE_W-1:0] ON_VALUE_RESET = 16'sd100;

endpackage

`default_nettype wire

FILE: hdl/binary_input_debounce_hold.sv
// Binary input debounce with hold-on delay; depends on bidh_pkg and assert_macros.svh.
// A sample is registered at its transfer; its result register loads when that stage fires.
// Throughput: one sample per cycle unless out_stall holds, set by the single stage of subtract and compare logic.
// Reset: arst_n clears configuration to its defaults and all debounce state to zero.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module binary_input_debounce_hold (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire bidh_pkg::cfg_idx_t                     cfg_index,
	input  wire logic [bidh_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic                                   raw_level,
	input  wire logic [bidh_pkg::TIME_W-1:0]            now_ms,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic signed [bidh_pkg::VALUE_W-1:0]         out_value,
	output logic                                        changed
);

	logic [bidh_pkg::MS_W-1:0]           bounce_ms_q;
	logic [bidh_pkg::MS_W-1:0]           hold_ms_q;
	logic                                invert_level_q;
	logic signed [bidh_pkg::VALUE_W-1:0] on_value_q;
	logic signed [bidh_pkg::VALUE_W-1:0] off_value_q;

	logic [bidh_pkg::TIME_W-1:0]         last_change_q;
	logic                                hold_active_q;
	logic [bidh_pkg::TIME_W-1:0]         hold_start_q;
	logic                                accepted_level_q;
	logic signed [bidh_pkg::VALUE_W-1:0] cur_value_q;

	logic                                valid_s1;
	logic                                level_s1;
	logic [bidh_pkg::TIME_W-1:0]         now_s1;

	logic                                out_valid_q;
	logic signed [bidh_pkg::VALUE_W-1:0] out_value_q;
	logic                                changed_q;

	logic                                out_ready;
	logic                                fire_s1;
	logic [bidh_pkg::TIME_W-1:0]         since_change;
	logic [bidh_pkg::TIME_W-1:0]         since_hold;
	logic                                lockout;
	logic                                hold_on;
	logic                                rising;
	logic                                hold_done;
	logic                                level_in;
	logic                                level_new;
	logic                                hold_active_new;
	logic signed [bidh_pkg::VALUE_W-1:0] mapped;
	logic                                chg;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounce_ms_q <= '0;
			hold_ms_q <= '0;
			invert_level_q <= 1'b0;
			on_value_q <= bidh_pkg::ON_VALUE_RESET;
			off_value_q <= bidh_pkg::NO_VALUE;
		end else if (cfg_we) begin
			case (cfg_index)
				bidh_pkg::REG_BOUNCE_MS: begin
					bounce_ms_q <= cfg_data[bidh_pkg::MS_W-1:0];
				end
				bidh_pkg::REG_HOLD_MS: begin
					hold_ms_q <= cfg_data[bidh_pkg::MS_W-1:0];
				end
				bidh_pkg::REG_INVERT_LEVEL: begin
					invert_level_q <= cfg_data[0];
				end
				bidh_pkg::REG_ON_VALUE: begin
					on_value_q <= $signed(cfg_data[bidh_pkg::VALUE_W-1:0]);
				end
				bidh_pkg::REG_OFF_VALUE: begin
					off_value_q <= $signed(cfg_data[bidh_pkg::VALUE_W-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	assign out_ready = !out_valid_q || !out_stall;
	assign fire_s1 = valid_s1 && out_ready;
	assign in_stall = valid_s1 && !out_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			level_s1 <= raw_level;
			now_s1 <= now_ms;
		end
	end

	// debounce and hold decision
	always_comb begin
		since_change = now_s1 - last_change_q;
		since_hold = now_s1 - hold_start_q;
		lockout = since_change < {{(bidh_pkg::TIME_W-bidh_pkg::MS_W){1'b0}}, bounce_ms_q};
		level_in = level_s1 ^ invert_level_q;
		hold_on = hold_ms_q != '0;
		rising = level_in && !accepted_level_q;
		hold_done = since_hold >= {{(bidh_pkg::TIME_W-bidh_pkg::MS_W){1'b0}}, hold_ms_q};
		level_new = level_in;
		hold_active_new = hold_active_q;
		if (hold_on) begin
			if (rising) begin
				if (hold_active_q) begin
					hold_active_new = !hold_done;
					level_new = hold_done;
				end else begin
					hold_active_new = 1'b1;
					level_new = accepted_level_q;
				end
			end else begin
				hold_active_new = 1'b0;
			end
		end
		mapped = level_new ? on_value_q : off_value_q;
		chg = (mapped != cur_value_q) && (mapped != bidh_pkg::NO_VALUE);
	end

	// debounce state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_change_q <= '0;
			hold_active_q <= 1'b0;
			hold_start_q <= '0;
			accepted_level_q <= 1'b0;
			cur_value_q <= '0;
		end else if (fire_s1 && !lockout) begin
			accepted_level_q <= level_new;
			cur_value_q <= mapped;
			hold_active_q <= hold_active_new;
			if (hold_on && rising && !hold_active_q) begin
				hold_start_q <= now_s1;
			end
			if (chg) begin
				last_change_q <= now_s1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			out_value_q <= lockout ? cur_value_q : mapped;
			changed_q <= !lockout && chg;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign changed = changed_q;

	`ASSERT_CLK(a_changed_has_value, clk, arst_n,
		out_valid_q && changed_q |-> out_value_q != bidh_pkg::NO_VALUE, "changed with no value")
	`ASSERT_CLK(a_fire_loads_result, clk, arst_n,
		fire_s1 |=> out_valid_q, "stage transfer did not load result")
	`ASSERT_CLK(a_change_time, clk, arst_n,
		fire_s1 && !lockout && chg |=> last_change_q == $past(now_s1), "change time not taken")
	`ASSERT_CLK(a_lockout_holds, clk, arst_n,
		fire_s1 && lockout |=> $stable(cur_value_q) && $stable(accepted_level_q),
		"state moved during lockout")
	`ASSERT_ALWAYS(a_stall_needs_item, clk,
		in_stall |-> valid_s1, "input stalled with empty stage")

endmodule

`default_nettype wire
